### rtl/fpa_pkg.sv
// fpa_pkg: shared types and constants of the fixed-point atan2 core.
// Used by the divider cells, the polynomial stages, the top level and the checker.
package fpa_pkg;

   localparam int CoordWidth = 16;
   localparam int AngleWidth = 16;
   localparam int QuoWidth   = 16;          // |quotient| <= 32768
   localparam int RemWidth   = QuoWidth + 1;
   localparam int DivCells   = QuoWidth;    // one quotient bit per cell
   // prep register + divider cells + three polynomial stages
   localparam int Latency    = 1 + DivCells + 3;

   localparam logic [11:0] PolyK1 = 12'd2847;
   localparam logic [13:0] PolyK2 = 14'd11039;

   localparam logic [15:0] TurnZero          = 16'd0;
   localparam logic [15:0] TurnEighth        = 16'd8192;
   localparam logic [15:0] TurnFiveEighths   = 16'd40960;
   localparam logic [15:0] TurnHalf          = 16'd32768;
   localparam logic [15:0] TurnQuarter       = 16'd16384;
   localparam logic [15:0] TurnThreeQuarters = 16'd49152;

   localparam logic [14:0] RoundTie  = 15'h4000;
   localparam logic [14:0] RoundBias = 15'h4000;

   // octant placement carried alongside the division
   typedef struct packed {
      logic                  special;   // equal coordinates: offset is the answer
      logic                  sub;       // offset minus polynomial
      logic [AngleWidth-1:0] offset;
   } meta_type;

   typedef struct packed {
      logic [RemWidth-1:0]   rem;
      logic [QuoWidth-1:0]   den;
      logic [QuoWidth-1:0]   quo;
      logic                  neg;       // quotient sign
      meta_type              meta;
   } div_data_type;

endpackage

### rtl/fpa_div_cell.sv
// fpa_div_cell: one restoring-division cell, resolves one quotient bit per beat.
// Depends on fpa_pkg.
module fpa_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  fpa_pkg::div_data_type in_data,
   output logic                 out_valid,
   output fpa_pkg::div_data_type out_data
);
   import fpa_pkg::*;

   logic                valid_ff;
   div_data_type        data_ff;
   div_data_type        data_in;
   logic                ge;
   logic [RemWidth-1:0] diff;

   always_comb begin
      ge      = in_data.rem >= {1'b0, in_data.den};
      diff    = ge ? (in_data.rem - {1'b0, in_data.den}) : in_data.rem;
      data_in = in_data;
      // remainder stays below the divisor, so the shift never drops a one
      data_in.rem = {diff[RemWidth-2:0], 1'b0};
      data_in.quo = {in_data.quo[QuoWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/fpa_poly.sv
// fpa_poly: correction polynomial r*(11039 - 2847*|r|) and octant placement.
// Three register stages; depends on fpa_pkg.
module fpa_poly (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [fpa_pkg::QuoWidth-1:0]    in_quo,
   input  logic                            in_neg,
   input  fpa_pkg::meta_type               in_meta,
   output logic                            out_valid,
   output logic [fpa_pkg::AngleWidth-1:0]  out_angle
);
   import fpa_pkg::*;

   // stage A: |r|*K1 and signed r
   logic                       a_valid_ff;
   logic [27:0]                a_prod_ff;
   logic signed [RemWidth-1:0] a_r_ff;
   meta_type                   a_meta_ff;
   logic signed [RemWidth-1:0] r_in;

   // stage B: (K2 - corr) * r
   logic                       b_valid_ff;
   logic signed [31:0]         b_prod_ff;
   meta_type                   b_meta_ff;
   logic [27:0]                a_sum;
   logic [11:0]                corr;
   logic [13:0]                k_val;

   // stage C: rounded u, offset applied
   logic                       c_valid_ff;
   logic [AngleWidth-1:0]      c_angle_ff;
   logic signed [31:0]         b_sum;
   logic [AngleWidth-1:0]      u_low;
   logic [AngleWidth-1:0]      angle_in;

   always_comb begin
      r_in = in_neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
   end

   // ties with low bits exactly one half get no bias
   always_comb begin
      a_sum = a_prod_ff + ((a_prod_ff[14:0] == RoundTie) ? 28'd0 : {13'd0, RoundBias});
      corr  = a_sum[26:15];
      k_val = PolyK2 - {2'b00, corr};
   end

   always_comb begin
      b_sum = b_prod_ff +
              ((b_prod_ff[14:0] == RoundTie) ? 32'sd0 : $signed({17'd0, RoundBias}));
      u_low = b_meta_ff.special ? '0 : b_sum[30:15];
      angle_in = b_meta_ff.sub ? (b_meta_ff.offset - u_low) : (b_meta_ff.offset + u_low);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_prod_ff  <= 28'(in_quo * PolyK1);
      a_r_ff     <= r_in;
      a_meta_ff  <= in_meta;
      b_prod_ff  <= 32'($signed({1'b0, k_val}) * a_r_ff);
      b_meta_ff  <= a_meta_ff;
      c_angle_ff <= angle_in;
   end

   assign out_valid = c_valid_ff;
   assign out_angle = c_angle_ff;

endmodule

### rtl/fixed_point_atan2_16bit_core.sv
// Fixed-point atan2 core: each beat passes the input register, the division cells and the
// polynomial stages in order; throughput one beat per cycle; busy is low whenever reset is low.
// The pipeline is the 16-cell division chain, one quotient bit per cell,
// plus an input stage and three polynomial stages (two multiplies, round and offset).
// Reset (synchronous, active high) clears all valid bits; beats in flight are dropped.
// Results cannot be stalled: rsp_valid pulses for one cycle per beat.
module fixed_point_atan2_16bit_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [fpa_pkg::CoordWidth-1:0] req_y_coord,
   input  logic signed [fpa_pkg::CoordWidth-1:0] req_x_coord,
   output logic                                rsp_valid,
   output logic [fpa_pkg::AngleWidth-1:0]      rsp_angle
);
   import fpa_pkg::*;

   // ---------------------------------------------------------------
   // Input stage: magnitudes, octant choice, divider operands.
   // The smaller magnitude is divided by the larger; equal coordinates
   // bypass the polynomial through the special flag.
   // ---------------------------------------------------------------
   logic                       accept;
   logic signed [RemWidth-1:0] y_ext;
   logic signed [RemWidth-1:0] x_ext;
   logic [RemWidth-1:0]        ay;
   logic [RemWidth-1:0]        ax;
   logic                       x_larger;
   div_data_type               prep_in;
   div_data_type               prep_ff;
   logic                       prep_valid_ff;

   // no beats while reset is held
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      y_ext    = {req_y_coord[CoordWidth-1], req_y_coord};
      x_ext    = {req_x_coord[CoordWidth-1], req_x_coord};
      ay       = req_y_coord[CoordWidth-1] ? RemWidth'(-y_ext) : RemWidth'(y_ext);
      ax       = req_x_coord[CoordWidth-1] ? RemWidth'(-x_ext) : RemWidth'(x_ext);
      x_larger = ax > ay;

      prep_in      = '0;
      prep_in.neg  = req_y_coord[CoordWidth-1] ^ req_x_coord[CoordWidth-1];
      prep_in.rem  = x_larger ? ay : ax;
      prep_in.den  = x_larger ? ax[QuoWidth-1:0] : ay[QuoWidth-1:0];
      prep_in.quo  = '0;

      priority if (req_x_coord == req_y_coord) begin
         // on the diagonal: the octant boundary in the first or third quadrant, or the zero vector
         prep_in.meta.special = 1'b1;
         prep_in.meta.sub     = 1'b0;
         if (req_y_coord == '0) begin
            prep_in.meta.offset = TurnZero;
         end else if (req_y_coord[CoordWidth-1]) begin
            prep_in.meta.offset = TurnFiveEighths;
         end else begin
            prep_in.meta.offset = TurnEighth;
         end
      end else if (x_larger) begin
         prep_in.meta.special = 1'b0;
         prep_in.meta.sub     = 1'b0;
         prep_in.meta.offset  = req_x_coord[CoordWidth-1] ? TurnHalf : TurnZero;
      end else begin
         // includes x == -y, where the quotient is exactly -1.0
         prep_in.meta.special = 1'b0;
         prep_in.meta.sub     = 1'b1;
         prep_in.meta.offset  = req_y_coord[CoordWidth-1] ? TurnThreeQuarters : TurnQuarter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   // ---------------------------------------------------------------
   // Division chain: each cell produces one Q15 quotient bit, MSB first.
   // ---------------------------------------------------------------
   logic         chain_valid [0:DivCells];
   div_data_type chain_data  [0:DivCells];

   assign chain_valid[0] = prep_valid_ff;
   assign chain_data[0]  = prep_ff;

   for (genvar i = 0; i < DivCells; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Polynomial correction and octant offset; output registered there.
   // ---------------------------------------------------------------
   fpa_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[DivCells]),
      .in_quo    (chain_data[DivCells].quo),
      .in_neg    (chain_data[DivCells].neg),
      .in_meta   (chain_data[DivCells].meta),
      .out_valid (rsp_valid),
      .out_angle (rsp_angle)
   );

endmodule

### rtl/fpa_checker.sv
// fpa_checker: port-level checks of the atan2 core, bound to the top level.
// Depends on fpa_pkg and fixed_point_atan2_16bit_core.
module fpa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [fpa_pkg::CoordWidth-1:0] req_y_coord,
   input logic signed [fpa_pkg::CoordWidth-1:0] req_x_coord,
   input logic                                rsp_valid,
   input logic [fpa_pkg::AngleWidth-1:0]      rsp_angle
);
   import fpa_pkg::*;

   logic beat_in;
   assign beat_in = start && !busy;

   // every accepted beat yields one result strobe after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      beat_in |-> ##Latency rsp_valid)
      else $error("missing result strobe");

   // diagonal in the first quadrant lands on one eighth turn
   a_diag: assert property (@(posedge clock) disable iff (reset)
      (beat_in && req_x_coord == req_y_coord && req_y_coord > 0)
         |-> ##Latency (rsp_angle == TurnEighth))
      else $error("diagonal angle wrong");

   // positive x axis gives zero
   a_xaxis: assert property (@(posedge clock) disable iff (reset)
      (beat_in && req_y_coord == 0 && req_x_coord > 0)
         |-> ##Latency (rsp_angle == TurnZero))
      else $error("x axis angle wrong");

   // positive y axis gives a quarter turn
   a_yaxis: assert property (@(posedge clock) disable iff (reset)
      (beat_in && req_x_coord == 0 && req_y_coord > 0)
         |-> ##Latency (rsp_angle == TurnQuarter))
      else $error("y axis angle wrong");

endmodule

bind fixed_point_atan2_16bit_core fpa_checker u_fpa_checker (.*);
